[src/c8_pkg.sv]
// c8_pkg: shared constants, state codes and helpers for the chip8 interpreter core
// no dependencies; used by the interfaces, the program memory, the top level and the bench
package c8_pkg;

  localparam int unsigned AddrW      = 12;
  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned ScreenW    = 64;
  localparam int unsigned ScreenH    = 32;
  localparam int unsigned RowIdxW    = 5;
  localparam int unsigned StackDepth = 16;
  localparam logic [AddrW-1:0] StartReset = 12'h200;

  // transfer function codes
  localparam logic [1:0] FuncStep  = 2'd0;
  localparam logic [1:0] FuncWrite = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] OpSys      = 4'h0;
  localparam logic [3:0] OpJump     = 4'h1;
  localparam logic [3:0] OpCall     = 4'h2;
  localparam logic [3:0] OpSeImm    = 4'h3;
  localparam logic [3:0] OpSneImm   = 4'h4;
  localparam logic [3:0] OpSeReg    = 4'h5;
  localparam logic [3:0] OpLdImm    = 4'h6;
  localparam logic [3:0] OpAddImm   = 4'h7;
  localparam logic [3:0] OpAlu      = 4'h8;
  localparam logic [3:0] OpSneReg   = 4'h9;
  localparam logic [3:0] OpLdIdx    = 4'hA;
  localparam logic [3:0] OpJumpV0   = 4'hB;
  localparam logic [3:0] OpRand     = 4'hC;
  localparam logic [3:0] OpDraw     = 4'hD;
  localparam logic [3:0] OpKey      = 4'hE;
  localparam logic [3:0] OpMisc     = 4'hF;

  // system group
  localparam logic [11:0] SysCls = 12'h0E0;
  localparam logic [11:0] SysRet = 12'h0EE;

  // alu group
  localparam logic [3:0] AluMov  = 4'h0;
  localparam logic [3:0] AluOr   = 4'h1;
  localparam logic [3:0] AluAnd  = 4'h2;
  localparam logic [3:0] AluXor  = 4'h3;
  localparam logic [3:0] AluAdd  = 4'h4;
  localparam logic [3:0] AluSub  = 4'h5;
  localparam logic [3:0] AluShr  = 4'h6;
  localparam logic [3:0] AluSubn = 4'h7;
  localparam logic [3:0] AluShl  = 4'hE;

  // key group
  localparam logic [7:0] KeyDown = 8'h9E;
  localparam logic [7:0] KeyUp   = 8'hA1;

  // misc group
  localparam logic [7:0] MiscGetDt  = 8'h07;
  localparam logic [7:0] MiscWaitK  = 8'h0A;
  localparam logic [7:0] MiscSetDt  = 8'h15;
  localparam logic [7:0] MiscSetSt  = 8'h18;
  localparam logic [7:0] MiscAddI   = 8'h1E;
  localparam logic [7:0] MiscFont   = 8'h29;
  localparam logic [7:0] MiscBcd    = 8'h33;
  localparam logic [7:0] MiscDump   = 8'h55;
  localparam logic [7:0] MiscLoad   = 8'h65;

  // sequencer states, one-hot
  typedef enum logic [16:0] {
    StIdle = 17'h00001,
    StRow  = 17'h00002,
    StF1   = 17'h00004,
    StF2   = 17'h00008,
    StRx   = 17'h00010,
    StRy   = 17'h00020,
    StEx   = 17'h00040,
    StWf   = 17'h00080,
    StBcd  = 17'h00100,
    StDrd  = 17'h00200,
    StDwr  = 17'h00400,
    StLrd  = 17'h00800,
    StLwr  = 17'h01000,
    StSrd  = 17'h02000,
    StSwr  = 17'h04000,
    StFin  = 17'h08000,
    StDone = 17'h10000
  } state_e;

  // hundreds, tens and ones of a byte as {h, t, o}
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0]  h;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [6:0]  r;
    logic [14:0] p;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = 7'(v - 8'd200);
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = 7'(v - 8'd100);
    end else begin
      h = 4'd0;
      r = v[6:0];
    end
    // r / 10 through a reciprocal, exact below 100
    p = 15'(r) * 15'd205;
    t = 4'(p >> 11);
    o = 4'(r - 7'(t) * 7'd10);
    return {h, t, o};
  endfunction

endpackage

[src/c8_if.sv]
// c8_in_if / c8_out_if: valid-ready channels of the chip8 interpreter core
// depends on c8_pkg for field widths
interface c8_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  func;
  logic [c8_pkg::AddrW-1:0]    addr;
  logic [7:0]                  write_byte;
  logic [15:0]                 keys;
  logic [7:0]                  random_byte;

  modport source (output valid, func, addr, write_byte, keys, random_byte, input ready);
  modport sink   (input valid, func, addr, write_byte, keys, random_byte, output ready);
endinterface

interface c8_out_if;
  logic                        valid;
  logic                        ready;
  logic [c8_pkg::ScreenW-1:0]  row_data;
  logic [c8_pkg::AddrW-1:0]    next_pc;
  logic                        screen_changed;
  logic                        sound_on;
  logic                        key_wait;
  logic                        bad_opcode;

  modport source (output valid, row_data, next_pc, screen_changed, sound_on, key_wait,
                  bad_opcode, input ready);
  modport sink   (input valid, row_data, next_pc, screen_changed, sound_on, key_wait,
                  bad_opcode, output ready);
endinterface

[src/c8_pmem.sv]
// c8_pmem: program memory, one write and one registered read port
// depends on c8_pkg for depth and address width
module c8_pmem (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [c8_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [c8_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [c8_pkg::MemBytes];
  logic [7:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/c8_vram.sv]
// c8_vram: small memory with per-entry valid bits so unwritten entries read zero
// used for the data registers, the return stack and the frame rows
module c8_vram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] valid_q;
  logic [Width-1:0] rdata_q;

  // data array and registered read, invalid entries read as zero
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  // valid bits, cleared at reset and on a clear request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/chip8_interpreter_core_top.sv]
// An item of func 0 runs one instruction from acceptance to result (fetch of two program
// bytes, two register reads, execute, timer tick, output load), and the next item is accepted
// once the sequencer is idle after that; a draw adds a sprite read and a frame write per row,
// FX55 and FX65 add a read and a write per register moved, FX33 adds a write per digit, and a
// flag write to VF, which every draw makes, adds a step. A memory write goes straight to the
// output load and a row read first reads the frame row. The order is set by the single read
// port of the program memory and of the register file, which sequences every access.
// The next item is accepted while a result still waits at the output register.
//
// chip8_interpreter_core_top: sequencer, register state and output register
// depends on c8_pkg, c8_if, c8_pmem and c8_vram
module chip8_interpreter_core_top #(
  parameter int unsigned STACK_DEPTH = c8_pkg::StackDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [c8_pkg::AddrW-1:0] cfg_wdata_i,
  c8_in_if.sink                    req_i,
  c8_out_if.source                 rsp_o
);

  localparam int unsigned SpW = $clog2(STACK_DEPTH);
  localparam int unsigned AW  = c8_pkg::AddrW;
  localparam int unsigned RW  = c8_pkg::RowIdxW;
  localparam int unsigned SW  = c8_pkg::ScreenW;

  c8_pkg::state_e state_q;

  logic [1:0]     func_q;
  logic [15:0]    keys_q;
  logic [7:0]     rnd_q;
  logic [7:0]     hi_q;
  logic [15:0]    op_q;
  logic [7:0]     vx_q;
  logic [7:0]     vy_q;
  logic [AW-1:0]  pc_q;
  logic [AW-1:0]  i_q;
  logic [AW-1:0]  next_q;
  logic [SpW-1:0] sp_q;
  logic [7:0]     dt_q;
  logic [7:0]     st_q;
  logic [3:0]     cnt_q;
  logic           hit_q;
  logic           flag_q;
  logic           changed_q;
  logic           kw_q;
  logic           bad_q;
  logic [SW-1:0]  row_q;

  logic           out_valid_q;
  logic [SW-1:0]  out_row_q;
  logic [AW-1:0]  out_pc_q;
  logic           out_changed_q;
  logic           out_sound_q;
  logic           out_kw_q;
  logic           out_bad_q;

  // memory ports
  logic           pm_we;
  logic [AW-1:0]  pm_waddr;
  logic [7:0]     pm_wdata;
  logic [AW-1:0]  pm_raddr;
  logic [7:0]     pm_rdata;
  logic           v_we;
  logic [3:0]     v_waddr;
  logic [7:0]     v_wdata;
  logic [3:0]     v_raddr;
  logic [7:0]     v_rdata;
  logic           stk_we;
  logic [AW-1:0]  stk_rdata;
  logic [SpW-1:0] sp_inc;
  logic [SpW-1:0] sp_dec;
  logic           fb_we;
  logic           fb_clr;
  logic [RW-1:0]  fb_waddr;
  logic [SW-1:0]  fb_wdata;
  logic [RW-1:0]  fb_raddr;
  logic [SW-1:0]  fb_rdata;

  // decode fields
  logic [3:0]     grp;
  logic [3:0]     x;
  logic [3:0]     n;
  logic [7:0]     nn;
  logic [AW-1:0]  nnn;
  logic [AW-1:0]  i_plus_cnt;
  logic [RW-1:0]  draw_row;
  logic [SW-1:0]  sprite_mask;
  logic [2*SW-1:0] sprite_dbl;
  logic [11:0]    digits;
  logic [3:0]     key_idx;
  logic           req_xfer;
  logic           rsp_load;
  logic           last_cnt;

  // execute results
  logic [7:0]     alu_res;
  logic           alu_flag;
  logic           alu_fwr;
  logic           alu_bad;
  logic [AW-1:0]  ex_next;
  logic           ex_vwe;
  logic [7:0]     ex_vdata;
  logic           ex_fwr;
  logic           ex_flag;
  logic           ex_bad;
  logic           ex_kw;
  logic           ex_iwe;
  logic [AW-1:0]  ex_i;
  logic           ex_cls;
  logic           ex_draw;
  logic           ex_push;
  logic           ex_pop;
  logic           ex_dtwe;
  logic           ex_stwe;
  c8_pkg::state_e ex_go;

  assign grp        = op_q[15:12];
  assign x          = op_q[11:8];
  assign n          = op_q[3:0];
  assign nn         = op_q[7:0];
  assign nnn        = op_q[11:0];
  assign i_plus_cnt = i_q + {8'd0, cnt_q};
  assign draw_row   = vy_q[RW-1:0] + {1'b0, cnt_q};
  assign digits     = c8_pkg::bcd_digits(vx_q);
  assign req_xfer   = req_i.valid && req_i.ready;
  assign rsp_load   = (state_q == c8_pkg::StDone) && (!out_valid_q || rsp_o.ready);
  assign last_cnt   = (cnt_q == x);
  assign sp_inc     = (sp_q == SpW'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec     = (sp_q == '0) ? SpW'(STACK_DEPTH - 1) : sp_q - 1'b1;

  // sprite row rotated right by the x position
  assign sprite_dbl  = {pm_rdata, 56'd0, pm_rdata, 56'd0} >> vx_q[5:0];
  assign sprite_mask = sprite_dbl[SW-1:0];

  // highest held key
  always_comb begin
    key_idx = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) begin
        key_idx = 4'(k);
      end
    end
  end

  // arithmetic group
  always_comb begin
    alu_res  = vx_q;
    alu_flag = 1'b0;
    alu_fwr  = 1'b0;
    alu_bad  = 1'b0;
    case (n)
      c8_pkg::AluMov: alu_res = vy_q;
      c8_pkg::AluOr:  alu_res = vx_q | vy_q;
      c8_pkg::AluAnd: alu_res = vx_q & vy_q;
      c8_pkg::AluXor: alu_res = vx_q ^ vy_q;
      c8_pkg::AluAdd: begin
        {alu_flag, alu_res} = {1'b0, vx_q} + {1'b0, vy_q};
        alu_fwr = 1'b1;
      end
      c8_pkg::AluSub: begin
        alu_res  = vx_q - vy_q;
        alu_flag = vx_q >= vy_q;
        alu_fwr  = 1'b1;
      end
      c8_pkg::AluShr: begin
        alu_res  = vx_q >> 1;
        alu_flag = vx_q[0];
        alu_fwr  = 1'b1;
      end
      c8_pkg::AluSubn: begin
        alu_res  = vy_q - vx_q;
        alu_flag = vy_q >= vx_q;
        alu_fwr  = 1'b1;
      end
      c8_pkg::AluShl: begin
        alu_res  = vx_q << 1;
        alu_flag = vx_q[7];
        alu_fwr  = 1'b1;
      end
      default: alu_bad = 1'b1;
    endcase
  end

  // instruction execute
  always_comb begin
    ex_next  = pc_q + 12'd2;
    ex_vwe   = 1'b0;
    ex_vdata = vx_q;
    ex_fwr   = 1'b0;
    ex_flag  = 1'b0;
    ex_bad   = 1'b0;
    ex_kw    = 1'b0;
    ex_iwe   = 1'b0;
    ex_i     = nnn;
    ex_cls   = 1'b0;
    ex_draw  = 1'b0;
    ex_push  = 1'b0;
    ex_pop   = 1'b0;
    ex_dtwe  = 1'b0;
    ex_stwe  = 1'b0;
    ex_go    = c8_pkg::StFin;
    case (grp)
      c8_pkg::OpSys: begin
        if (nnn == c8_pkg::SysCls) begin
          ex_cls = 1'b1;
        end else if (nnn == c8_pkg::SysRet) begin
          ex_pop  = 1'b1;
          ex_next = stk_rdata + 12'd2;
        end else begin
          ex_bad = 1'b1;
        end
      end
      c8_pkg::OpJump: ex_next = nnn;
      c8_pkg::OpCall: begin
        ex_push = 1'b1;
        ex_next = nnn;
      end
      c8_pkg::OpSeImm:  if (vx_q == nn) ex_next = pc_q + 12'd4;
      c8_pkg::OpSneImm: if (vx_q != nn) ex_next = pc_q + 12'd4;
      c8_pkg::OpSeReg:  if (vx_q == vy_q) ex_next = pc_q + 12'd4;
      c8_pkg::OpSneReg: if (vx_q != vy_q) ex_next = pc_q + 12'd4;
      c8_pkg::OpLdImm: begin
        ex_vwe   = 1'b1;
        ex_vdata = nn;
      end
      c8_pkg::OpAddImm: begin
        ex_vwe   = 1'b1;
        ex_vdata = vx_q + nn;
      end
      c8_pkg::OpAlu: begin
        ex_vwe   = !alu_bad;
        ex_vdata = alu_res;
        ex_fwr   = alu_fwr;
        ex_flag  = alu_flag;
        ex_bad   = alu_bad;
      end
      c8_pkg::OpLdIdx: ex_iwe = 1'b1;
      // V0 was fetched into the second operand slot
      c8_pkg::OpJumpV0: ex_next = nnn + {4'd0, vy_q};
      c8_pkg::OpRand: begin
        ex_vwe   = 1'b1;
        ex_vdata = rnd_q & nn;
      end
      c8_pkg::OpDraw: begin
        ex_draw = 1'b1;
        ex_go   = (n == 4'd0) ? c8_pkg::StWf : c8_pkg::StSrd;
      end
      c8_pkg::OpKey: begin
        if (nn == c8_pkg::KeyDown) begin
          if (keys_q[vx_q[3:0]]) ex_next = pc_q + 12'd4;
        end else if (nn == c8_pkg::KeyUp) begin
          if (!keys_q[vx_q[3:0]]) ex_next = pc_q + 12'd4;
        end else begin
          ex_bad = 1'b1;
        end
      end
      default: begin
        case (nn)
          c8_pkg::MiscGetDt: begin
            ex_vwe   = 1'b1;
            ex_vdata = dt_q;
          end
          c8_pkg::MiscWaitK: begin
            if (keys_q == 16'd0) begin
              ex_next = pc_q;
              ex_kw   = 1'b1;
            end else begin
              ex_vwe   = 1'b1;
              ex_vdata = {4'd0, key_idx};
            end
          end
          c8_pkg::MiscSetDt: ex_dtwe = 1'b1;
          c8_pkg::MiscSetSt: ex_stwe = 1'b1;
          c8_pkg::MiscAddI: begin
            ex_iwe = 1'b1;
            ex_i   = i_q + {4'd0, vx_q};
          end
          c8_pkg::MiscFont: begin
            ex_iwe = 1'b1;
            ex_i   = {6'd0, vx_q[3:0], 2'd0} + {8'd0, vx_q[3:0]};
          end
          c8_pkg::MiscBcd:  ex_go = c8_pkg::StBcd;
          c8_pkg::MiscDump: ex_go = c8_pkg::StDrd;
          c8_pkg::MiscLoad: ex_go = c8_pkg::StLrd;
          default: ex_bad = 1'b1;
        endcase
      end
    endcase
    if (ex_fwr) begin
      ex_go = c8_pkg::StWf;
    end
  end

  // memory port steering by sequencer state
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = i_plus_cnt;
    pm_wdata = v_rdata;
    pm_raddr = pc_q;
    v_we     = 1'b0;
    v_waddr  = x;
    v_wdata  = ex_vdata;
    v_raddr  = cnt_q;
    stk_we   = 1'b0;
    fb_we    = 1'b0;
    fb_clr   = 1'b0;
    fb_waddr = draw_row;
    fb_wdata = fb_rdata ^ sprite_mask;
    fb_raddr = draw_row;
    case (state_q)
      c8_pkg::StIdle: begin
        pm_we    = req_xfer && (req_i.func == c8_pkg::FuncWrite);
        pm_waddr = req_i.addr;
        pm_wdata = req_i.write_byte;
        fb_raddr = req_i.addr[RW-1:0];
      end
      c8_pkg::StF1: pm_raddr = pc_q + 12'd1;
      c8_pkg::StF2: v_raddr = hi_q[3:0];
      c8_pkg::StRx: v_raddr = (grp == c8_pkg::OpJumpV0) ? 4'd0 : op_q[7:4];
      c8_pkg::StEx: begin
        v_we   = ex_vwe;
        stk_we = ex_push;
        fb_clr = ex_cls;
      end
      c8_pkg::StWf: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, flag_q};
      end
      c8_pkg::StBcd: begin
        pm_we = 1'b1;
        case (cnt_q[1:0])
          2'd0:    pm_wdata = {4'd0, digits[11:8]};
          2'd1:    pm_wdata = {4'd0, digits[7:4]};
          default: pm_wdata = {4'd0, digits[3:0]};
        endcase
      end
      c8_pkg::StDwr: pm_we = 1'b1;
      c8_pkg::StLrd: pm_raddr = i_plus_cnt;
      c8_pkg::StLwr: begin
        v_we    = 1'b1;
        v_waddr = cnt_q;
        v_wdata = pm_rdata;
      end
      c8_pkg::StSrd: pm_raddr = i_plus_cnt;
      c8_pkg::StSwr: fb_we = 1'b1;
      default: ;
    endcase
  end

  // sequencer and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= c8_pkg::StIdle;
      pc_q      <= c8_pkg::StartReset;
      i_q       <= '0;
      sp_q      <= '0;
      dt_q      <= '0;
      st_q      <= '0;
      cnt_q     <= '0;
      changed_q <= 1'b0;
      kw_q      <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      case (state_q)
        c8_pkg::StIdle: begin
          if (req_xfer) begin
            changed_q <= 1'b0;
            kw_q      <= 1'b0;
            bad_q     <= 1'b0;
            case (req_i.func)
              c8_pkg::FuncStep: state_q <= c8_pkg::StF1;
              c8_pkg::FuncRead: state_q <= c8_pkg::StRow;
              default:          state_q <= c8_pkg::StDone;
            endcase
          end
        end
        c8_pkg::StRow: state_q <= c8_pkg::StDone;
        c8_pkg::StF1:  state_q <= c8_pkg::StF2;
        c8_pkg::StF2:  state_q <= c8_pkg::StRx;
        c8_pkg::StRx:  state_q <= c8_pkg::StRy;
        c8_pkg::StRy:  state_q <= c8_pkg::StEx;
        c8_pkg::StEx: begin
          cnt_q     <= '0;
          bad_q     <= ex_bad;
          kw_q      <= ex_kw;
          changed_q <= ex_cls || ex_draw;
          if (ex_iwe) i_q <= ex_i;
          if (ex_push) sp_q <= sp_inc;
          if (ex_pop) sp_q <= sp_dec;
          if (ex_dtwe) dt_q <= vx_q;
          if (ex_stwe) st_q <= vx_q;
          state_q <= ex_go;
        end
        c8_pkg::StWf: state_q <= c8_pkg::StFin;
        c8_pkg::StBcd: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd2) state_q <= c8_pkg::StFin;
        end
        c8_pkg::StDrd: state_q <= c8_pkg::StDwr;
        c8_pkg::StLrd: state_q <= c8_pkg::StLwr;
        c8_pkg::StDwr, c8_pkg::StLwr: begin
          cnt_q <= cnt_q + 4'd1;
          if (last_cnt) begin
            i_q     <= i_q + {8'd0, x} + 12'd1;
            state_q <= c8_pkg::StFin;
          end else begin
            state_q <= (state_q == c8_pkg::StDwr) ? c8_pkg::StDrd : c8_pkg::StLrd;
          end
        end
        c8_pkg::StSrd: state_q <= c8_pkg::StSwr;
        c8_pkg::StSwr: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == n - 4'd1) begin
            state_q <= c8_pkg::StWf;
          end else begin
            state_q <= c8_pkg::StSrd;
          end
        end
        c8_pkg::StFin: begin
          pc_q <= next_q;
          if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
          if (st_q != 8'd0) st_q <= st_q - 8'd1;
          state_q <= c8_pkg::StDone;
        end
        c8_pkg::StDone: begin
          if (rsp_load) state_q <= c8_pkg::StIdle;
        end
        default: state_q <= c8_pkg::StIdle;
      endcase
    end
  end

  // item and instruction capture
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      func_q <= req_i.func;
      keys_q <= req_i.keys;
      rnd_q  <= req_i.random_byte;
      row_q  <= '0;
    end
    if (state_q == c8_pkg::StRow) row_q <= fb_rdata;
    if (state_q == c8_pkg::StF1) hi_q <= pm_rdata;
    if (state_q == c8_pkg::StF2) op_q <= {hi_q, pm_rdata};
    if (state_q == c8_pkg::StRx) vx_q <= v_rdata;
    if (state_q == c8_pkg::StRy) vy_q <= v_rdata;
    if (state_q == c8_pkg::StEx) begin
      next_q <= ex_next;
      flag_q <= ex_flag;
      hit_q  <= 1'b0;
    end
    if (state_q == c8_pkg::StSwr) begin
      hit_q  <= hit_q || ((fb_rdata & sprite_mask) != '0);
      flag_q <= hit_q || ((fb_rdata & sprite_mask) != '0);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      out_row_q     <= (func_q == c8_pkg::FuncRead) ? row_q : '0;
      out_pc_q      <= pc_q;
      out_changed_q <= changed_q;
      out_sound_q   <= st_q != 8'd0;
      out_kw_q      <= kw_q;
      out_bad_q     <= bad_q;
    end
  end

  assign req_i.ready          = (state_q == c8_pkg::StIdle);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.row_data       = out_row_q;
  assign rsp_o.next_pc        = out_pc_q;
  assign rsp_o.screen_changed = out_changed_q;
  assign rsp_o.sound_on       = out_sound_q;
  assign rsp_o.key_wait       = out_kw_q;
  assign rsp_o.bad_opcode     = out_bad_q;

  // memories
  c8_pmem u_pmem (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata)
  );

  c8_vram #(.Width(8), .Depth(16)) u_vregs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  c8_vram #(.Width(AW), .Depth(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (1'b0),
    .we_i    (stk_we),
    .waddr_i (sp_q),
    .wdata_i (pc_q),
    .raddr_i (sp_dec),
    .rdata_o (stk_rdata)
  );

  c8_vram #(.Width(SW), .Depth(c8_pkg::ScreenH)) u_frame (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (fb_clr),
    .we_i    (fb_we),
    .waddr_i (fb_waddr),
    .wdata_i (fb_wdata),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  // checks
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> state_q != c8_pkg::StIdle)
    else $error("sequencer idle after input transfer");

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, sp_q} < (SpW + 1)'(STACK_DEPTH))
    else $error("stack pointer out of range");

  a_one_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> $countones({rsp_o.screen_changed, rsp_o.key_wait, rsp_o.bad_opcode}) <= 1)
    else $error("conflicting status flags");

endmodule

[bench/chip8_interpreter_core_top_tb.sv]
`timescale 1ns / 1ps
// chip8_interpreter_core_top_tb: self-checking bench for the chip8 interpreter core
// depends on c8_pkg, c8_if and chip8_interpreter_core_top; keeps its own instruction-level model
module chip8_interpreter_core_top_tb;

  localparam logic [1:0] FuncNone = 2'd3;  // unused function code
  localparam int unsigned IdleLimit = 3000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  wbyte;
    logic [15:0] keys;
    logic [7:0]  rnd;
  } cmd_t;

  typedef struct packed {
    logic [63:0] row;
    logic [11:0] pc;
    logic        chg;
    logic        snd;
    logic        kw;
    logic        bad;
  } result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [c8_pkg::AddrW-1:0] cfg_wdata_i;

  c8_in_if  req ();
  c8_out_if rsp ();

  chip8_interpreter_core_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // machine state mirrored by the predictor
  logic [7:0]  mem_m [c8_pkg::MemBytes];
  logic        wr_m  [c8_pkg::MemBytes];
  logic [63:0] fb_m  [c8_pkg::ScreenH];
  logic [7:0]  v_m   [16];
  logic [11:0] stk_m [16];
  logic [11:0] i_m;
  logic [11:0] pc_m;
  logic [3:0]  sp_m;
  logic [7:0]  dt_m;
  logic [7:0]  st_m;

  result_t exp_q [$];
  int unsigned errors;
  int unsigned n_checked;
  int unsigned n_steps;
  int unsigned n_draws;
  int unsigned n_waits;
  int unsigned n_bad;
  int unsigned burst_left;
  int unsigned idle_cnt;
  logic hold_req;
  int unsigned hold_left;
  int unsigned rx_cyc;

  // expected result of one item, updating the mirrored state
  function automatic result_t predict_item(cmd_t q);
    result_t o;
    logic [15:0] op;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  n;
    logic [7:0]  nn;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [11:0] nxt;
    logic [63:0] m;
    logic [6:0]  px;
    logic [4:0]  row;
    logic        hit;
    o = '0;
    case (q.func)
      c8_pkg::FuncStep: begin
        n_steps++;
        op  = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
        x   = op[11:8];
        y   = op[7:4];
        n   = op[3:0];
        nn  = op[7:0];
        nxt = pc_m + 12'd2;
        a   = v_m[x];
        b   = v_m[y];
        case (op[15:12])
          c8_pkg::OpSys: begin
            if (op[11:0] == c8_pkg::SysCls) begin
              for (int r = 0; r < c8_pkg::ScreenH; r++) fb_m[r] = '0;
              o.chg = 1'b1;
            end else if (op[11:0] == c8_pkg::SysRet) begin
              sp_m = sp_m - 4'd1;
              nxt  = stk_m[sp_m] + 12'd2;
            end else begin
              o.bad = 1'b1;
            end
          end
          c8_pkg::OpJump: nxt = op[11:0];
          c8_pkg::OpCall: begin
            stk_m[sp_m] = pc_m;
            sp_m = sp_m + 4'd1;
            nxt  = op[11:0];
          end
          c8_pkg::OpSeImm:  if (a == nn) nxt = nxt + 12'd2;
          c8_pkg::OpSneImm: if (a != nn) nxt = nxt + 12'd2;
          c8_pkg::OpSeReg:  if (a == b) nxt = nxt + 12'd2;
          c8_pkg::OpSneReg: if (a != b) nxt = nxt + 12'd2;
          c8_pkg::OpLdImm:  v_m[x] = nn;
          c8_pkg::OpAddImm: v_m[x] = a + nn;
          c8_pkg::OpAlu: begin
            case (n)
              c8_pkg::AluMov: v_m[x] = b;
              c8_pkg::AluOr:  v_m[x] = a | b;
              c8_pkg::AluAnd: v_m[x] = a & b;
              c8_pkg::AluXor: v_m[x] = a ^ b;
              // flag lands in VF after the result, so it wins when X is F
              c8_pkg::AluAdd: begin
                v_m[x] = a + b;
                v_m[15] = {7'd0, (9'(a) + 9'(b)) > 9'd255};
              end
              c8_pkg::AluSub: begin
                v_m[x] = a - b;
                v_m[15] = {7'd0, a >= b};
              end
              c8_pkg::AluShr: begin
                v_m[x] = a >> 1;
                v_m[15] = {7'd0, a[0]};
              end
              c8_pkg::AluSubn: begin
                v_m[x] = b - a;
                v_m[15] = {7'd0, b >= a};
              end
              c8_pkg::AluShl: begin
                v_m[x] = a << 1;
                v_m[15] = {7'd0, a[7]};
              end
              default: o.bad = 1'b1;
            endcase
          end
          c8_pkg::OpLdIdx:  i_m = op[11:0];
          c8_pkg::OpJumpV0: nxt = op[11:0] + {4'd0, v_m[0]};
          c8_pkg::OpRand:   v_m[x] = q.rnd & nn;
          c8_pkg::OpDraw: begin
            // sprite rows wrap both horizontally and vertically
            px  = {1'b0, a[5:0]};
            hit = 1'b0;
            for (int r = 0; r < n; r++) begin
              m = {mem_m[i_m + 12'(r)], 56'd0};
              if (px != 0) m = (m >> px) | (m << (7'd64 - px));
              row = b[4:0] + 5'(r);
              if ((fb_m[row] & m) != 0) hit = 1'b1;
              fb_m[row] = fb_m[row] ^ m;
            end
            v_m[15] = {7'd0, hit};
            o.chg = 1'b1;
          end
          c8_pkg::OpKey: begin
            if (nn == c8_pkg::KeyDown) begin
              if (q.keys[a[3:0]]) nxt = nxt + 12'd2;
            end else if (nn == c8_pkg::KeyUp) begin
              if (!q.keys[a[3:0]]) nxt = nxt + 12'd2;
            end else begin
              o.bad = 1'b1;
            end
          end
          default: begin
            case (nn)
              c8_pkg::MiscGetDt: v_m[x] = dt_m;
              c8_pkg::MiscWaitK: begin
                // highest held key wins; no key holds pc
                if (q.keys == 16'd0) begin
                  nxt  = pc_m;
                  o.kw = 1'b1;
                end else begin
                  for (int k = 0; k < 16; k++) if (q.keys[k]) v_m[x] = 8'(k);
                end
              end
              c8_pkg::MiscSetDt: dt_m = a;
              c8_pkg::MiscSetSt: st_m = a;
              c8_pkg::MiscAddI:  i_m = i_m + {4'd0, a};
              c8_pkg::MiscFont:  i_m = 12'(a[3:0]) * 12'd5;
              c8_pkg::MiscBcd: begin
                mem_m[i_m]          = a / 8'd100;
                mem_m[i_m + 12'd1]  = (a / 8'd10) % 8'd10;
                mem_m[i_m + 12'd2]  = a % 8'd10;
                wr_m[i_m]           = 1'b1;
                wr_m[i_m + 12'd1]   = 1'b1;
                wr_m[i_m + 12'd2]   = 1'b1;
              end
              c8_pkg::MiscDump: begin
                for (int k = 0; k <= x; k++) begin
                  mem_m[i_m + 12'(k)] = v_m[k];
                  wr_m[i_m + 12'(k)]  = 1'b1;
                end
                i_m = i_m + 12'(x) + 12'd1;
              end
              c8_pkg::MiscLoad: begin
                for (int k = 0; k <= x; k++) v_m[k] = mem_m[i_m + 12'(k)];
                i_m = i_m + 12'(x) + 12'd1;
              end
              default: o.bad = 1'b1;
            endcase
          end
        endcase
        pc_m = nxt;
        if (dt_m != 0) dt_m = dt_m - 8'd1;
        if (st_m != 0) st_m = st_m - 8'd1;
        if (o.chg) n_draws++;
        if (o.kw) n_waits++;
        if (o.bad) n_bad++;
      end
      c8_pkg::FuncWrite: begin
        mem_m[q.addr] = q.wbyte;
        wr_m[q.addr]  = 1'b1;
      end
      c8_pkg::FuncRead: o.row = fb_m[q.addr[4:0]];
      default: ;
    endcase
    o.pc  = pc_m;
    o.snd = (st_m != 0);
    return o;
  endfunction

  // random instruction spread over every group, mostly well-formed
  function automatic logic [15:0] random_opcode();
    logic [3:0] g;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] nn;
    g  = 4'($urandom);
    x  = 4'($urandom);
    y  = 4'($urandom);
    nn = 8'($urandom);
    case (g)
      c8_pkg::OpSys: begin
        case ($urandom_range(0, 3))
          0: return {4'h0, c8_pkg::SysCls};
          1, 2: return {4'h0, c8_pkg::SysRet};
          default: return {4'h0, x, nn};
        endcase
      end
      c8_pkg::OpAlu: begin
        case ($urandom_range(0, 9))
          0: return {g, x, y, c8_pkg::AluMov};
          1: return {g, x, y, c8_pkg::AluOr};
          2: return {g, x, y, c8_pkg::AluAnd};
          3: return {g, x, y, c8_pkg::AluXor};
          4: return {g, x, y, c8_pkg::AluAdd};
          5: return {g, x, y, c8_pkg::AluSub};
          6: return {g, x, y, c8_pkg::AluShr};
          7: return {g, x, y, c8_pkg::AluSubn};
          8: return {g, x, y, c8_pkg::AluShl};
          default: return {g, x, y, nn[3:0]};
        endcase
      end
      c8_pkg::OpKey: begin
        case ($urandom_range(0, 4))
          0, 1: return {g, x, c8_pkg::KeyDown};
          2, 3: return {g, x, c8_pkg::KeyUp};
          default: return {g, x, nn};
        endcase
      end
      c8_pkg::OpMisc: begin
        case ($urandom_range(0, 9))
          0: return {g, x, c8_pkg::MiscGetDt};
          1: return {g, x, c8_pkg::MiscWaitK};
          2: return {g, x, c8_pkg::MiscSetDt};
          3: return {g, x, c8_pkg::MiscSetSt};
          4: return {g, x, c8_pkg::MiscAddI};
          5: return {g, x, c8_pkg::MiscFont};
          6: return {g, x, c8_pkg::MiscBcd};
          7: return {g, x, c8_pkg::MiscDump};
          8: return {g, x, c8_pkg::MiscLoad};
          default: return {g, x, nn};
        endcase
      end
      default: return {g, x, nn};
    endcase
  endfunction

  // one input transfer; called at a rising edge, returns at the edge that accepted it
  task automatic send_item(cmd_t q);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    req.valid       <= 1'b1;
    req.func        <= q.func;
    req.addr        <= q.addr;
    req.write_byte  <= q.wbyte;
    req.keys        <= q.keys;
    req.random_byte <= q.rnd;
    do @(negedge clk_i); while (!req.ready);
    @(posedge clk_i);
    exp_q.push_back(predict_item(q));
  endtask

  task automatic send_cmd(logic [1:0] func, logic [11:0] addr, logic [7:0] wbyte,
                          logic [15:0] keys, logic [7:0] rnd);
    cmd_t q;
    q = '{func, addr, wbyte, keys, rnd};
    send_item(q);
  endtask

  function automatic logic [15:0] random_keys();
    return ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
  endfunction

  // give a never-written byte a random value
  task automatic fill_byte(logic [11:0] addr);
    if (!wr_m[addr])
      send_cmd(c8_pkg::FuncWrite, addr, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // step at the current pc, first loading any program, sprite or load byte it would read unwritten
  task automatic step_here(logic [15:0] keys, logic [7:0] rnd);
    logic [15:0] op;
    fill_byte(pc_m);
    fill_byte(pc_m + 12'd1);
    op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
    if (op[15:12] == c8_pkg::OpDraw) begin
      for (int r = 0; r < op[3:0]; r++) fill_byte(i_m + 12'(r));
    end
    if (op[15:12] == c8_pkg::OpMisc && op[7:0] == c8_pkg::MiscLoad) begin
      for (int k = 0; k <= op[11:8]; k++) fill_byte(i_m + 12'(k));
    end
    send_cmd(c8_pkg::FuncStep, 12'($urandom), 8'($urandom), keys, rnd);
  endtask

  // place an opcode at the current pc and execute it
  task automatic run_opcode(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
    send_cmd(c8_pkg::FuncWrite, pc_m, op[15:8], 16'($urandom), 8'($urandom));
    send_cmd(c8_pkg::FuncWrite, pc_m + 12'd1, op[7:0], 16'($urandom), 8'($urandom));
    step_here(keys, rnd);
  endtask

  // drop valid and let every expected result drain
  task automatic wait_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_start(logic [11:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pc_m = value;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    run_opcode(16'h603F, 16'd0, 8'd0);          // V0 = 63, right edge
    run_opcode(16'h611F, 16'd0, 8'd0);          // V1 = 31, bottom edge
    run_opcode(16'hAFFE, 16'd0, 8'd0);          // I near top of memory
    run_opcode(16'hD01F, 16'd0, 8'd0);          // 15-row sprite wrapping both ways
    run_opcode(16'hD01F, 16'd0, 8'd0);          // same again, collision
    send_cmd(c8_pkg::FuncRead, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
    send_cmd(c8_pkg::FuncRead, 12'h000, 8'h00, 16'h0000, 8'h00);
    run_opcode(16'h00E0, 16'd0, 8'd0);          // clear screen
    run_opcode(16'h6205, 16'd0, 8'd0);
    run_opcode(16'h8327, 16'd0, 8'd0);          // VY - VX
    run_opcode(16'h6FFF, 16'd0, 8'd0);
    run_opcode(16'h8FF4, 16'd0, 8'd0);          // carry flag overwrites VF as target
    run_opcode(16'h5010, 16'd0, 8'd0);          // register compare, no write
    run_opcode(16'hC0A5, 16'd0, 8'hFF);         // random byte masked
    run_opcode(16'hF00A, 16'd0, 8'd0);          // no key held, pc stays
    run_opcode(16'hF00A, 16'h8001, 8'd0);       // highest key taken
    run_opcode(16'hFF55, 16'd0, 8'd0);          // dump with address wrap
    run_opcode(16'hFF65, 16'd0, 8'd0);
    run_opcode(16'h2ABC, 16'd0, 8'd0);          // call, then return
    run_opcode(16'h00EE, 16'd0, 8'd0);
    run_opcode(16'h0123, 16'd0, 8'd0);          // unknown opcode
    run_opcode(16'hF118, 16'd0, 8'd0);          // sound timer on
    send_cmd(FuncNone, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
  endtask

  // mostly placed instructions, some straight steps over memory, writes, reads and noise
  task automatic run_random(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
          run_opcode(random_opcode(), random_keys(), 8'($urandom));
        11, 12, 13, 14:
          step_here(random_keys(), 8'($urandom));
        15, 16:
          send_cmd(c8_pkg::FuncWrite, 12'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom));
        17, 18:
          send_cmd(c8_pkg::FuncRead, 12'($urandom), 8'($urandom), 16'($urandom),
                   8'($urandom));
        default:
          send_cmd(FuncNone, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic test_start_address();
    logic [11:0] starts [4];
    starts = '{12'h000, 12'hFFF, 12'($urandom), c8_pkg::StartReset};
    foreach (starts[s]) begin
      wait_idle();
      write_start(starts[s]);
      run_random(15);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    run_random(40);
  endtask

  // receiver stall pattern, with a long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rx_cyc    <= 0;
      hold_left <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left <= HoldCycles;
        rsp.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        case (rx_cyc[9:8])
          2'd0: rsp.ready <= 1'b1;
          2'd1: rsp.ready <= ($urandom_range(0, 3) != 0);
          2'd2: rsp.ready <= (rx_cyc[3:0] > 4'd5);
          default: rsp.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // result check and watchdog, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin
    result_t act;
    result_t e;
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cnt = 0;
      else idle_cnt++;
      if (rsp.valid && rsp.ready) begin
        act = '{rsp.row_data, rsp.next_pc, rsp.screen_changed, rsp.sound_on, rsp.key_wait,
                rsp.bad_opcode};
        if (exp_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: pc=%h", act.pc);
        end else begin
          e = exp_q.pop_front();
          n_checked++;
          if (act !== e) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp row=%h pc=%h chg=%b snd=%b kw=%b bad=%b",
                       e.row, e.pc, e.chg, e.snd, e.kw, e.bad);
              $display("          got row=%h pc=%h chg=%b snd=%b kw=%b bad=%b",
                       act.row, act.pc, act.chg, act.snd, act.kw, act.bad);
            end
          end
        end
      end
      if (idle_cnt >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req.valid       = 1'b0;
    req.func        = c8_pkg::FuncStep;
    req.addr        = '0;
    req.write_byte  = '0;
    req.keys        = '0;
    req.random_byte = '0;
    hold_req        = 1'b0;
    errors = 0;
    n_checked = 0;
    n_steps = 0;
    n_draws = 0;
    n_waits = 0;
    n_bad = 0;
    burst_left = 0;
    idle_cnt = 0;
    foreach (mem_m[a]) mem_m[a] = '0;
    foreach (wr_m[a]) wr_m[a] = 1'b0;
    foreach (fb_m[r]) fb_m[r] = '0;
    foreach (v_m[r]) v_m[r] = '0;
    foreach (stk_m[r]) stk_m[r] = '0;
    i_m  = '0;
    pc_m = c8_pkg::StartReset;
    sp_m = '0;
    dt_m = '0;
    st_m = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_start_address();
    wait_idle();
    run_random(100);
    test_backpressure();
    run_random(100);
    wait_idle();

    $display("checked %0d results: %0d steps, %0d screen updates, %0d key waits, %0d bad opcodes",
             n_checked, n_steps, n_draws, n_waits, n_bad);
    $display("start address set to both ends and midrange, one long output stall");
    if (errors == 0 && exp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d errors, %0d results missing", errors, exp_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
